### rtl/core/smoothstep_motion_profile_macros.svh
// assertion macros shared by the motion profile rtl
`ifndef SMOOTHSTEP_MOTION_PROFILE_MACROS_SVH
`define SMOOTHSTEP_MOTION_PROFILE_MACROS_SVH

// same-cycle implication, checked out of reset
`define SMP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("smp check failed");

// next-cycle implication, checked out of reset
`define SMP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("smp check failed");

`endif

### rtl/core/smp_pkg.sv
// shared constants and types of the motion profile
package smp_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int FRAC_BITS      = 24;
    localparam int INTEG_W        = 50;

    localparam logic [49:0] INTEG_MAX = 50'h3_FFFF_FFFF_FFFF;

    localparam logic [31:0] RAMP_UP_RST   = 32'd1024;
    localparam logic [31:0] CRUISE_RST    = 32'd1024;
    localparam logic [31:0] RAMP_DOWN_RST = 32'd1024;
    localparam logic [31:0] PEAK_RST      = 32'd65536;

    typedef enum logic [1:0] {
        REG_RAMP_UP   = 2'd0,
        REG_CRUISE    = 2'd1,
        REG_RAMP_DOWN = 2'd2,
        REG_PEAK      = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_UP     = 3'd1,
        PH_CRUISE = 3'd2,
        PH_DOWN   = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

endpackage

### rtl/core/smp_front.sv
// front end: segment classification and integral base of a query
module smp_front #(
    parameter int TIME_WIDTH = smp_pkg::TIME_WIDTH_DEF
) (
    input  logic [31:0]               i_time,
    input  logic [31:0]               i_ramp_up,
    input  logic [31:0]               i_cruise,
    input  logic [31:0]               i_ramp_down,
    output logic [2*TIME_WIDTH+52:0]  o_item
);
    localparam int W  = TIME_WIDTH;
    localparam int W1 = W + 1;
    localparam int W2 = W + 2;
    localparam int BW = (W + 18 > 51) ? W + 18 : 51;

    logic [W-1:0]  t, ru, cr, rd, num, den;
    logic [W1-1:0] d1;
    logic [W2-1:0] d2;
    logic [BW-1:0] s_cruise, s_rc, s_done, bsel;
    logic [49:0]   base;
    smp_pkg::t_phase ph;

    always_comb begin
        t  = W'(i_time);
        ru = W'(i_ramp_up);
        cr = W'(i_cruise);
        rd = W'(i_ramp_down);
        d1 = W1'(t) - W1'(ru);
        d2 = W2'(t) - W2'(ru) - W2'(cr);
        s_cruise = (BW'(ru) << 15) + (BW'(d1[W-1:0]) << 16);
        s_rc     = (BW'(ru) << 15) + (BW'(cr) << 16);
        s_done   = s_rc + (BW'(rd) << 15);
        num  = '0;
        den  = '0;
        bsel = '0;
        if (t == '0) begin
            ph = smp_pkg::PH_START;
        end else if (d1[W]) begin
            ph  = smp_pkg::PH_UP;
            num = t;
            den = ru;
        end else if (d2[W+1]) begin
            ph   = smp_pkg::PH_CRUISE;
            bsel = s_cruise;
        end else if (d2[W-1:0] < rd) begin
            ph   = smp_pkg::PH_DOWN;
            num  = d2[W-1:0];
            den  = rd;
            bsel = s_rc;
        end else begin
            ph   = smp_pkg::PH_DONE;
            bsel = s_done;
        end
        // clamp to the 50-bit integral range
        base = (bsel > BW'(smp_pkg::INTEG_MAX)) ? smp_pkg::INTEG_MAX : bsel[49:0];
        o_item = {base, den, num, ph};
    end

endmodule

### rtl/core/smp_queue.sv
// two-entry queue between front and back end
module smp_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid & o_ready;
    assign pop     = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
    end

endmodule

### rtl/core/smp_back.sv
// back end: pipelined divider, smoothstep polynomials and scaling
`include "smoothstep_motion_profile_macros.svh"
module smp_back #(
    parameter int TIME_WIDTH = smp_pkg::TIME_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [2*TIME_WIDTH+52:0]  i_item,
    input  logic [31:0]               i_peak_speed,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [16:0]               o_throttle,
    output logic [31:0]               o_speed,
    output logic [49:0]               o_integ,
    output logic [63:0]               o_distance,
    output logic [2:0]                o_phase
);
    localparam int W  = TIME_WIDTH;
    localparam int W1 = W + 1;
    localparam int IW = 2 * W + 53;
    localparam int NF = smp_pkg::FRAC_BITS;
    localparam int DW = (W > 24) ? W : 25;
    localparam int HW = DW - 24;
    localparam int SW = ((DW + 17 > 50) ? DW + 17 : 50) + 1;
    localparam int NS = NF + 7;

    logic en;
    logic [NS-1:0] r_vld;
    logic          r_out_v;

    // divider stages
    logic [W-1:0]  r_rem [NF];
    logic [23:0]   r_q   [NF];
    logic [IW-1:0] r_itm [NF];
    logic [W-1:0]  n_rem [NF];
    logic [23:0]   n_q   [NF];
    logic [W1-1:0] sh;
    logic [W-1:0]  src_rem, den_k;
    logic [23:0]   src_q;

    // polynomial and scaling stages
    logic [IW-1:0] r_a_itm, r_b_itm, r_c_itm, r_d_itm, r_e_itm;
    logic [23:0]   r_a_x, r_a_x2, r_b_x, r_b_x3, r_c_x, r_c_x3, r_c_x4, r_d_g;
    logic [24:0]   r_b_s;
    logic [16:0]   r_c_thr, r_d_thr, r_e_thr, r_f_thr, r_g_thr;
    logic [DW-1:0] r_e_ph;
    logic [47:0]   r_e_pl;
    logic [49:0]   r_f_integ, r_g_integ;
    logic [2:0]    r_f_phase, r_g_phase;
    logic [48:0]   r_g_pthr;
    logic [47:0]   r_g_plo, r_g_pmid;
    logic [49:0]   r_g_phi;
    logic          r_g_neg;

    logic [16:0]   r_thr;
    logic [31:0]   r_speed;
    logic [49:0]   r_integ;
    logic [63:0]   r_dist;
    logic [2:0]    r_phase;

    logic [23:0]   x_div;
    logic [25:0]   cub;
    logic [16:0]   n_thr;
    logic [23:0]   f_val, n_g;
    logic [DW-1:0] den_e;
    logic [HW-1:0] hi;
    logic [23:0]   lo;
    logic [SW-1:0] part, isum;
    logic [49:0]   n_integ;
    logic          neg;
    logic [31:0]   mag, v, n_speed;
    logic [66:0]   m;
    logic [63:0]   mc, n_dist;

    assign en      = !r_out_v || i_ready;
    assign o_ready = en;

    // one restoring-division step per stage
    always_comb begin
        for (int k = 0; k < NF; k++) begin
            if (k == 0) begin
                src_rem = i_item[W+2:3];
                src_q   = '0;
                den_k   = i_item[2*W+2:W+3];
            end else begin
                src_rem = r_rem[k-1];
                src_q   = r_q[k-1];
                den_k   = r_itm[k-1][2*W+2:W+3];
            end
            sh = {src_rem, 1'b0};
            if (sh >= W1'(den_k)) begin
                n_rem[k] = W'(sh - W1'(den_k));
                n_q[k]   = {src_q[22:0], 1'b1};
            end else begin
                n_rem[k] = W'(sh);
                n_q[k]   = {src_q[22:0], 1'b0};
            end
        end
    end

    always_comb begin
        x_div = r_q[NF-1];
        cub   = 26'd50331648 - {1'b0, r_a_x, 1'b0};
        case (r_b_itm[2:0])
            smp_pkg::PH_UP:     n_thr = 17'((26'(r_b_s) + 26'd128) >> 8);
            smp_pkg::PH_DOWN:   n_thr = 17'((26'd16777216 - 26'(r_b_s) + 26'd128) >> 8);
            smp_pkg::PH_CRUISE: n_thr = 17'd65536;
            default:            n_thr = 17'd0;
        endcase
        f_val = r_c_x3 - {1'b0, r_c_x4[23:1]};
        n_g   = (r_c_itm[2:0] == smp_pkg::PH_DOWN) ? (r_c_x - f_val) : f_val;
        den_e = DW'(r_d_itm[2*W+2:W+3]);
        hi    = den_e[DW-1:24];
        lo    = den_e[23:0];
        part  = (SW'(r_e_ph) << 16) + SW'(r_e_pl >> 8);
        if (r_e_itm[2:0] == smp_pkg::PH_UP || r_e_itm[2:0] == smp_pkg::PH_DOWN) begin
            isum = SW'(r_e_itm[IW-1:2*W+3]) + part;
        end else begin
            isum = SW'(r_e_itm[IW-1:2*W+3]);
        end
        n_integ = (isum > SW'(smp_pkg::INTEG_MAX)) ? smp_pkg::INTEG_MAX : isum[49:0];
        neg     = i_peak_speed[31];
        mag     = neg ? (32'd0 - i_peak_speed) : i_peak_speed;
        v       = r_g_pthr[47:16];
        n_speed = r_g_neg ? (32'd0 - v) : v;
        m  = (67'(r_g_phi) << 16) + 67'(r_g_pmid) + 67'(r_g_plo >> 16);
        if (r_g_neg) begin
            mc     = (m > 67'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : m[63:0];
            n_dist = 64'd0 - mc;
        end else begin
            mc     = (m > 67'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : m[63:0];
            n_dist = mc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_vld   <= {r_vld[NS-2:0], i_valid};
            r_out_v <= r_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NF; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_itm[k] <= (k == 0) ? i_item : r_itm[k-1];
            end
            r_a_itm <= r_itm[NF-1];
            r_a_x   <= x_div;
            r_a_x2  <= 24'((48'(x_div) * 48'(x_div)) >> 24);
            r_b_itm <= r_a_itm;
            r_b_x   <= r_a_x;
            r_b_s   <= 25'((50'(r_a_x2) * 50'(cub)) >> 24);
            r_b_x3  <= 24'((48'(r_a_x2) * 48'(r_a_x)) >> 24);
            r_c_itm <= r_b_itm;
            r_c_x   <= r_b_x;
            r_c_x3  <= r_b_x3;
            r_c_x4  <= 24'((48'(r_b_x3) * 48'(r_b_x)) >> 24);
            r_c_thr <= n_thr;
            r_d_itm <= r_c_itm;
            r_d_thr <= r_c_thr;
            r_d_g   <= n_g;
            r_e_itm <= r_d_itm;
            r_e_thr <= r_d_thr;
            r_e_ph  <= DW'(HW'(hi) * DW'(r_d_g));
            r_e_pl  <= 48'(lo) * 48'(r_d_g);
            r_f_thr   <= r_e_thr;
            r_f_integ <= n_integ;
            r_f_phase <= r_e_itm[2:0];
            r_g_thr   <= r_f_thr;
            r_g_integ <= r_f_integ;
            r_g_phase <= r_f_phase;
            r_g_neg   <= neg;
            r_g_pthr  <= 49'(mag) * 49'(r_f_thr);
            r_g_plo   <= 48'(mag) * 48'(r_f_integ[15:0]);
            r_g_pmid  <= 48'(mag) * 48'(r_f_integ[31:16]);
            r_g_phi   <= 50'(mag) * 50'(r_f_integ[49:32]);
            r_thr   <= r_g_thr;
            r_speed <= n_speed;
            r_integ <= r_g_integ;
            r_dist  <= n_dist;
            r_phase <= r_g_phase;
        end
    end

    assign o_valid    = r_out_v;
    assign o_throttle = r_thr;
    assign o_speed    = r_speed;
    assign o_integ    = r_integ;
    assign o_distance = r_dist;
    assign o_phase    = r_phase;

    `SMP_ASSERT_NOW(a_cruise_full, r_out_v && r_phase == smp_pkg::PH_CRUISE, r_thr == 17'd65536)
    `SMP_ASSERT_NOW(a_start_zero, r_out_v && r_phase == smp_pkg::PH_START, r_thr == 17'd0 && r_integ == 50'd0)
    `SMP_ASSERT_NOW(a_done_still, r_out_v && r_phase == smp_pkg::PH_DONE, r_thr == 17'd0 && r_speed == 32'd0)
    `SMP_ASSERT_NEXT(a_div_flow, en && r_vld[NF-1], r_vld[NF])

endmodule

### rtl/core/smoothstep_motion_profile.sv
// top level of the smoothstep ramp, cruise, ramp motion profile
// a query is held in the queue register, then passes the divider stages and the math stages
// throughput: one query per cycle while the result stream is ready; every stage advances together
// the 24-step restoring divider for the ramp fraction sets the depth, not the rate
// results wait in the output register; the queue keeps taking beats while it has room
// reset (i_rst_n low, synchronous) empties queue and pipeline and loads register defaults
module smoothstep_motion_profile #(
    parameter int TIME_WIDTH = smp_pkg::TIME_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_data,
    // query stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] time_ticks
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [167:0] m_axis_tdata    // throttle, speed, profile_integral, distance, phase, pad
);
    localparam int IW = 2 * TIME_WIDTH + 53;

    logic [31:0]   r_ramp_up, r_cruise, r_ramp_down, r_peak;
    logic [IW-1:0] front_item, q_item;
    logic          q_valid, q_ready;
    logic [16:0]   thr;
    logic [31:0]   speed;
    logic [49:0]   integ;
    logic [63:0]   distance;
    logic [2:0]    phase;

    // register file, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_up   <= smp_pkg::RAMP_UP_RST;
            r_cruise    <= smp_pkg::CRUISE_RST;
            r_ramp_down <= smp_pkg::RAMP_DOWN_RST;
            r_peak      <= smp_pkg::PEAK_RST;
        end else if (i_cfg_valid) begin
            case (smp_pkg::t_reg_idx'(i_cfg_addr))
                smp_pkg::REG_RAMP_UP:   r_ramp_up   <= i_cfg_data;
                smp_pkg::REG_CRUISE:    r_cruise    <= i_cfg_data;
                smp_pkg::REG_RAMP_DOWN: r_ramp_down <= i_cfg_data;
                smp_pkg::REG_PEAK:      r_peak      <= i_cfg_data;
                default:                ;
            endcase
        end
    end

    // front: classify the query time into a segment
    smp_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
        .i_time      (s_axis_tdata),
        .i_ramp_up   (r_ramp_up),
        .i_cruise    (r_cruise),
        .i_ramp_down (r_ramp_down),
        .o_item      (front_item)
    );

    // short queue decouples acceptance from the back pipeline stall
    smp_queue #(.WIDTH(IW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (front_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_item)
    );

    // back: ramp fraction, smoothstep, integral and speed scaling
    smp_back #(.TIME_WIDTH(TIME_WIDTH)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .o_ready      (q_ready),
        .i_item       (q_item),
        .i_peak_speed (r_peak),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_throttle   (thr),
        .o_speed      (speed),
        .o_integ      (integ),
        .o_distance   (distance),
        .o_phase      (phase)
    );

    // result beat layout, lowest bit first
    assign m_axis_tdata = {2'b00, phase, distance, integ, speed, thr};

endmodule
